// ----- src/bin_aabb_pair_overlap_finder_defines.svh -----
// Assertion macros used by the checker file of the overlap finder.
`ifndef BIN_AABB_PAIR_OVERLAP_FINDER_DEFINES_SVH
`define BIN_AABB_PAIR_OVERLAP_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BAOF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overlap finder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BAOF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("overlap finder check failed");

`endif

// ----- src/baof_pkg.sv -----
`default_nettype none

package baof_pkg;

    localparam int ID_W  = 24;
    localparam int CRD_W = 32;
    localparam int FAM_W = 16;
    localparam int IN_W  = 248;
    localparam int OUT_W = 48;

    // Packed so that the lowest bits hold body_id, matching the input word layout.
    typedef struct packed {
        logic signed [FAM_W-1:0] excluded_family;
        logic signed [FAM_W-1:0] family;
        logic signed [CRD_W-1:0] max_z;
        logic signed [CRD_W-1:0] max_y;
        logic signed [CRD_W-1:0] max_x;
        logic signed [CRD_W-1:0] min_z;
        logic signed [CRD_W-1:0] min_y;
        logic signed [CRD_W-1:0] min_x;
        logic [ID_W-1:0]         body_id;
    } body_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] low_id;
        logic [ID_W-1:0] high_id;
    } match_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } fsm_state_t;

endpackage

`default_nettype wire

// ----- src/baof_cell.sv -----
`default_nettype none

module baof_cell
    import baof_pkg::*;
(
    input  wire        clk,
    input  cell_ctrl_t ctrl,
    input  body_t      shift_in,
    input  body_t      load_data,
    output body_t      entry
);

    body_t body_reg;
    body_t body_next;

    // Rotate with the ring, or take a newly appended body.
    always_comb
    begin
        body_next = body_reg;
        if (ctrl.load)
        begin
            body_next = load_data;
        end
        else if (ctrl.shift)
        begin
            body_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg <= body_next;
    end

    assign entry = body_reg;

endmodule

`default_nettype wire

// ----- src/baof_cmp.sv -----
`default_nettype none

module baof_cmp
    import baof_pkg::*;
(
    input  body_t  query,
    input  body_t  entry,
    output match_t result
);

    logic ovl_x;
    logic ovl_y;
    logic ovl_z;
    logic fam_ok;
    logic id_diff;
    logic entry_lower;

    // Inclusive overlap on each axis, signed compares.
    assign ovl_x = ($signed(query.min_x) <= $signed(entry.max_x)) &&
                   ($signed(entry.min_x) <= $signed(query.max_x));
    assign ovl_y = ($signed(query.min_y) <= $signed(entry.max_y)) &&
                   ($signed(entry.min_y) <= $signed(query.max_y));
    assign ovl_z = ($signed(query.min_z) <= $signed(entry.max_z)) &&
                   ($signed(entry.min_z) <= $signed(query.max_z));

    // Neither body may sit in the other's excluded family.
    assign fam_ok = (query.family != entry.excluded_family) &&
                    (entry.family != query.excluded_family);

    assign id_diff     = query.body_id != entry.body_id;
    assign entry_lower = entry.body_id < query.body_id;

    // Order the pair with the smaller id first.
    always_comb
    begin
        result.hit     = id_diff && ovl_x && ovl_y && ovl_z && fam_ok;
        result.low_id  = entry_lower ? entry.body_id : query.body_id;
        result.high_id = entry_lower ? query.body_id : entry.body_id;
    end

endmodule

`default_nettype wire

// ----- src/bin_aabb_pair_overlap_finder.sv -----
`default_nettype none

// Broadphase pair finder for one spatial bin. Each input word is one body (id, 16.16
// box, family, excluded family); s_tuser set starts a new bin and empties the store.
// The stored bodies sit in a ring of BIN_CAPACITY cells that rotates past a single
// comparator, one stored body per cycle except while a further pair waits on a stalled
// result side. A body is accepted, then passes BIN_CAPACITY rotation steps and a
// closing step that appends it if the store has room and releases the final pair;
// only then can the next body be taken. Output words carry {high_id, low_id}; m_tlast
// marks the last pair caused by a body and m_tuser reports that the store was full and
// the body was not kept. At most BIN_CAPACITY-1 pairs are reported per body, the first
// ones in arrival order.
module bin_aabb_pair_overlap_finder
    import baof_pkg::*;
#(
    parameter int BIN_CAPACITY = 32
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    // body_id[23:0], min_x, min_y, min_z, max_x, max_y, max_z, family, excluded_family
    input  wire  [IN_W-1:0]  s_tdata,
    // start_bin
    input  wire              s_tuser,
    output logic             m_tvalid,
    input  wire              m_tready,
    // low_id[23:0], high_id[47:24]
    output logic [OUT_W-1:0] m_tdata,
    // bin_overflowed
    output logic             m_tuser,
    output logic             m_tlast
);

    localparam int IDX_W = $clog2(BIN_CAPACITY);
    localparam int CNT_W = $clog2(BIN_CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BIN_CAPACITY - 1);
    localparam logic [IDX_W-1:0] PAIR_MAX  = IDX_W'(BIN_CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(BIN_CAPACITY);

    fsm_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] npair_reg, npair_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    body_t            query_reg, query_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]  pend_low_reg, pend_low_next;
    logic [ID_W-1:0]  pend_high_reg, pend_high_next;

    logic             out_valid_reg, out_valid_next;
    logic [ID_W-1:0]  out_low_reg, out_low_next;
    logic [ID_W-1:0]  out_high_reg, out_high_next;
    logic             out_last_reg, out_last_next;
    logic             out_ovf_reg, out_ovf_next;

    body_t            entries [BIN_CAPACITY];
    cell_ctrl_t       cell_ctrl [BIN_CAPACITY];
    match_t           match;

    logic accept;
    logic in_range;
    logic take;
    logic out_free;
    logic advance;
    logic push_out;
    logic flush_out;
    logic flush_done;
    logic rotate;
    logic append;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Ring of cells: cell 0 is the head that meets the comparator.
    for (genvar k = 0; k < BIN_CAPACITY; k++)
    begin : g_cell
        always_comb
        begin
            cell_ctrl[k].shift = rotate;
            cell_ctrl[k].load  = append && (count_reg == CNT_W'(k));
        end

        baof_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[k]),
            .shift_in  (entries[(k + 1) % BIN_CAPACITY]),
            .load_data (query_reg),
            .entry     (entries[k])
        );
    end

    baof_cmp u_cmp (
        .query  (query_reg),
        .entry  (entries[0]),
        .result (match)
    );

    // Test the head entry: only live entries count, and cap the pairs per body.
    assign in_range = CNT_W'(idx_reg) < count_reg;
    assign take     = in_range && match.hit && (npair_reg != PAIR_MAX);

    // A new pair displaces the held one, which then needs a free output register.
    assign advance    = !take || !pend_valid_reg || out_free;
    assign flush_done = !pend_valid_reg || out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (advance && (idx_reg == LAST_IDX))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb
    begin
        s_tready  = 1'b0;
        rotate    = 1'b0;
        push_out  = 1'b0;
        flush_out = 1'b0;
        append    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SCAN:
            begin
                rotate   = advance;
                push_out = take && pend_valid_reg && out_free;
            end
            ST_FLUSH:
            begin
                flush_out = pend_valid_reg && out_free;
                append    = flush_done && !ovf_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Body bookkeeping: capture the query, walk the ring, count the store.
    always_comb
    begin
        query_next = query_reg;
        idx_next   = idx_reg;
        npair_next = npair_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            query_next = body_t'(s_tdata);
            idx_next   = '0;
            npair_next = '0;
            if (s_tuser)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                ovf_next = count_reg == CAP_COUNT;
            end
        end
        if (rotate)
        begin
            idx_next = idx_reg + 1'b1;
            if (take)
            begin
                npair_next = npair_reg + 1'b1;
            end
        end
        if (append)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Hold one pair back so the last pair of a body can be marked.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_low_next   = pend_low_reg;
        pend_high_next  = pend_high_reg;
        if (rotate && take)
        begin
            pend_valid_next = 1'b1;
            pend_low_next   = match.low_id;
            pend_high_next  = match.high_id;
        end
        else if (flush_out)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // Output register: load the held pair, drop it once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (push_out || flush_out)
        begin
            out_valid_next = 1'b1;
            out_low_next   = pend_low_reg;
            out_high_next  = pend_high_reg;
            out_last_next  = flush_out;
            out_ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            npair_reg      <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            npair_reg      <= npair_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg     <= query_next;
        pend_low_reg  <= pend_low_next;
        pend_high_reg <= pend_high_next;
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_high_reg, out_low_reg};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- src/baof_checker.sv -----
`default_nettype none

`include "bin_aabb_pair_overlap_finder_defines.svh"

module baof_checker
    import baof_pkg::*;
(
    input wire             clk,
    input wire             rst_n,
    input wire             s_tvalid,
    input wire             s_tready,
    input wire             m_tvalid,
    input wire             m_tready,
    input wire [OUT_W-1:0] m_tdata,
    input wire             m_tuser,
    input wire             m_tlast
);

    // A stalled output word keeps its contents.
    `BAOF_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Ids of a pair always differ and come smaller first.
    `BAOF_ASSERT_IMP(a_pair_order, clk, rst_n, m_tvalid, m_tdata[23:0] < m_tdata[47:24])

    // A body is worked on before the next one is taken.
    `BAOF_ASSERT_NXT(a_one_body, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A new pair is only produced while a body is being worked on.
    `BAOF_ASSERT_IMP(a_out_busy, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

bind bin_aabb_pair_overlap_finder baof_checker u_baof_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- test/bin_aabb_pair_overlap_finder_tb.sv -----
module bin_aabb_pair_overlap_finder_tb;
    import baof_pkg::*;

    localparam int CAPACITY   = 32;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_PRINTS = 50;
    localparam logic signed [CRD_W-1:0] CRD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CRD_W-1:0] CRD_MIN = 32'sh8000_0000;

    typedef struct {
        logic  start;
        body_t body;
    } bin_word_t;

    typedef struct {
        logic [ID_W-1:0] low_id;
        logic [ID_W-1:0] high_id;
        logic            overflowed;
        logic            last;
    } pair_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    // Stimulus and expectation stores
    bin_word_t pending_bodies[$];
    bin_word_t offered;
    pair_t     expected_pairs[$];

    // Predictor copy of the bin store
    body_t     bin_bodies[CAPACITY];
    int        bin_count = 0;

    int        send_idle_pct = 0;
    int        stall_pct = 0;
    logic      receiver_hold = 1'b0;
    int        error_count = 0;
    int        bin_center[3];

    bin_aabb_pair_overlap_finder #(
        .BIN_CAPACITY(CAPACITY)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic logic boxes_overlap(input body_t a, input body_t b);
        return ($signed(a.min_x) <= $signed(b.max_x)) && ($signed(b.min_x) <= $signed(a.max_x))
            && ($signed(a.min_y) <= $signed(b.max_y)) && ($signed(b.min_y) <= $signed(a.max_y))
            && ($signed(a.min_z) <= $signed(b.max_z)) && ($signed(b.min_z) <= $signed(a.max_z));
    endfunction

    // Test the new body against the stored ones, queue its pairs, then store it if the bin has room
    task automatic predict_pairs(input body_t b, input logic start);
        int    hits[$];
        int    i;
        logic  full;
        pair_t p;
        if (start)
            bin_count = 0;
        full = (bin_count >= CAPACITY);
        for (i = 0; i < bin_count && hits.size() < CAPACITY - 1; i++)
        begin
            if (bin_bodies[i].body_id == b.body_id)
                continue;
            if (!boxes_overlap(b, bin_bodies[i]))
                continue;
            if ($signed(b.family) == $signed(bin_bodies[i].excluded_family)
                || $signed(bin_bodies[i].family) == $signed(b.excluded_family))
                continue;
            hits.push_back(i);
        end
        foreach (hits[k])
        begin
            p.low_id     = (bin_bodies[hits[k]].body_id < b.body_id)
                           ? bin_bodies[hits[k]].body_id : b.body_id;
            p.high_id    = (bin_bodies[hits[k]].body_id < b.body_id)
                           ? b.body_id : bin_bodies[hits[k]].body_id;
            p.overflowed = full;
            p.last       = (k == hits.size() - 1);
            expected_pairs.push_back(p);
        end
        if (!full)
        begin
            bin_bodies[bin_count] = b;
            bin_count++;
        end
    endtask

    task automatic queue_body(input logic start, input logic [ID_W-1:0] id,
                              input int mnx, input int mny, input int mnz,
                              input int mxx, input int mxy, input int mxz,
                              input int fam, input int exc);
        bin_word_t w;
        w.start                = start;
        w.body.body_id         = id;
        w.body.min_x           = mnx;
        w.body.min_y           = mny;
        w.body.min_z           = mnz;
        w.body.max_x           = mxx;
        w.body.max_y           = mxy;
        w.body.max_z           = mxz;
        w.body.family          = fam[FAM_W-1:0];
        w.body.excluded_family = exc[FAM_W-1:0];
        pending_bodies.push_back(w);
    endtask

    function automatic logic [FAM_W-1:0] pick_family();
        case ($urandom_range(5))
            0: return 16'sd0;
            1: return 16'sd1;
            2: return -16'sd1;
            3: return 16'h8000;
            4: return 16'h7FFF;
            default: return FAM_W'($urandom);
        endcase
    endfunction

    // Dense spans contain the bin center, loose ones scatter and sometimes invert; wild ones are at times random
    function automatic void axis_span(input int c, input bit dense, input bit wild,
                                      output int lo, output int hi);
        if (wild && $urandom_range(9) == 0)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else if (dense)
        begin
            lo = c - int'($urandom_range(4000));
            hi = c + int'($urandom_range(4000));
        end
        else
        begin
            lo = c + int'($urandom_range(60000)) - 30000;
            hi = lo + int'($urandom_range(30000)) - 2000;
        end
    endfunction

    // Fill random bins; a full bin packs overlapping bodies past capacity
    task automatic queue_random_bins(input int count, input bit with_full_bin);
        int              left;
        int              size;
        int              k;
        int              a;
        bit              dense;
        bit              full_bin;
        int              lo[3];
        int              hi[3];
        int              fam;
        int              exc;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] used_ids[$];
        left = count;
        full_bin = with_full_bin;
        while (left > 0)
        begin
            size = full_bin ? CAPACITY + 4 : int'($urandom_range(1, 8));
            if (size > left)
                size = left;
            dense = full_bin || ($urandom_range(1) == 1);
            for (a = 0; a < 3; a++)
                bin_center[a] = $urandom;
            used_ids.delete();
            for (k = 0; k < size; k++)
            begin
                if (full_bin)
                    id = used_ids.size() == 0 ? ID_W'($urandom) : used_ids[$] + 1'b1;
                else if (used_ids.size() != 0 && $urandom_range(99) < 15)
                    id = used_ids[$urandom_range(used_ids.size() - 1)];
                else
                    id = ID_W'($urandom);
                used_ids.push_back(id);
                for (a = 0; a < 3; a++)
                    axis_span(bin_center[a], dense, !full_bin, lo[a], hi[a]);
                fam = full_bin ? 0 : int'($signed(pick_family()));
                exc = full_bin ? 1 : int'($signed(pick_family()));
                queue_body(k == 0, id, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], fam, exc);
            end
            left -= size;
            full_bin = 1'b0;
        end
    endtask

    task automatic wait_sender_drained();
        while (pending_bodies.size() != 0 || s_tvalid)
            @(posedge clk);
    endtask

    // Offer bodies from the pending queue; predict each one as it is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                predict_pairs(offered.body, offered.start);
            if (pending_bodies.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offered = pending_bodies.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= offered.body;
                s_tuser  <= offered.start;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, or hold it off entirely on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !receiver_hold && ($urandom_range(99) >= stall_pct);
    end

    // Check each accepted pair against the oldest expected one
    always @(posedge clk)
    begin
        pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pairs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pair %h/%h ovf %b last %b",
                                          m_tdata[23:0], m_tdata[47:24], m_tuser, m_tlast));
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (m_tdata[23:0] !== want.low_id || m_tdata[47:24] !== want.high_id
                    || m_tuser !== want.overflowed || m_tlast !== want.last)
                    report_mismatch($sformatf(
                        "pair got %h/%h ovf %b last %b, wanted %h/%h ovf %b last %b",
                        m_tdata[23:0], m_tdata[47:24], m_tuser, m_tlast,
                        want.low_id, want.high_id, want.overflowed, want.last));
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: full space, points, both exclusion directions, equal ids,
        // inverted box, touching and just-missing edges per axis, corner extremes
        queue_body(1, 24'h000000, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX, 0, 32767);
        queue_body(0, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, -32768, -1);
        queue_body(0, 24'h000005, 0, 0, 0, 0, 0, 0, 32767, -32768);
        queue_body(0, 24'h000000, 0, 0, 0, 0, 0, 0, 1, 2);
        queue_body(0, 24'h000007, 10, -5, -5, -10, 5, 5, 3, 3);
        queue_body(0, 24'h000008, 0, -1, -1, 100, 1, 1, 4, 4);
        queue_body(0, 24'h000009, 1, -1, -1, 2, 1, 1, 5, 6);
        queue_body(0, 24'h00000A, -1, 1, -1, 1, 2, 1, 5, 6);
        queue_body(0, 24'h00000B, -1, -1, 1, 1, 1, 2, 5, 6);
        queue_body(0, 24'h00000C, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX,
                   -32768, 32767);
        queue_body(0, 24'h00000D, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN,
                   32767, 0);
        queue_body(1, 24'h800000, -65536, -65536, -65536, 65536, 65536, 65536, -1, 0);
        queue_body(0, 24'h7FFFFF, -65536, -65536, -65536, 65536, 65536, 65536, 0, -1);
        queue_body(0, 24'h800000, -65536, -65536, -65536, 65536, 65536, 65536, 2, 2);
        queue_body(0, 24'h000001, -65536, -65536, -65536, 65536, 65536, 65536, 5, 6);
        wait_sender_drained();

        // No idling, with a long hold-off on the result side
        queue_random_bins(40, 1'b1);
        fork
            begin
                receiver_hold <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                receiver_hold <= 1'b0;
            end
        join_none
        wait_sender_drained();

        // Sender mostly idle
        send_idle_pct <= 72;
        stall_pct     <= 0;
        queue_random_bins(30, 1'b0);
        wait_sender_drained();

        // Receiver mostly stalling
        send_idle_pct <= 0;
        stall_pct     <= 72;
        queue_random_bins(30, 1'b0);
        wait_sender_drained();

        // Both sides idling now and then
        send_idle_pct <= 24;
        stall_pct     <= 24;
        queue_random_bins(30, 1'b0);
        wait_sender_drained();

        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 8) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/baof_pkg.sv
src/baof_cell.sv
src/baof_cmp.sv
src/bin_aabb_pair_overlap_finder.sv
src/baof_checker.sv
test/bin_aabb_pair_overlap_finder_tb.sv
